FILE: hw/rtl/lsw_pkg.sv
// Shared types, constants, microcode ROM and segment table for the LCD serial writer.
package lsw_pkg;

   // Operation codes carried in the request beat
   localparam logic [1:0] OP_CMD   = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_SHOW  = 2'd2;
   localparam logic [1:0] OP_INC   = 2'd3;

   // Frame layout: frames are held left aligned in a 13-bit shifter
   localparam int unsigned FRAME_W = 13;
   localparam logic [3:0]  CMD_BITS   = 4'd12;
   localparam logic [3:0]  WRITE_BITS = 4'd13;
   localparam logic [2:0]  MODE_CMD   = 3'b100;
   localparam logic [2:0]  MODE_WRITE = 3'b101;
   // Segment writes go to addresses 4..7: upper address bits fixed
   localparam logic [3:0]  SEG_ADDR_HI = 4'b0001;

   // Number handling
   localparam logic [6:0]  VALUE_MAX   = 7'd99;
   localparam logic [7:0]  DIV10_MUL   = 8'd205;
   localparam int unsigned DIV10_SHIFT = 11;
   localparam logic [3:0]  DIGIT_MAX   = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_SHIFT
   } state_type;

   typedef enum logic [1:0] {
      FR_NONE,
      FR_CMD,
      FR_WRITE,
      FR_SEG
   } frame_type;

   typedef enum logic [1:0] {
      NUM_KEEP,
      NUM_VALUE,
      NUM_INC
   } num_type;

   typedef logic [2:0] upc_type;

   // Microcode addresses; the first four are the entry points for each op
   localparam upc_type UA_CMD      = 3'd0;
   localparam upc_type UA_WRITE    = 3'd1;
   localparam upc_type UA_SHOW     = 3'd2;
   localparam upc_type UA_INC      = 3'd3;
   localparam upc_type UA_TENS_HI  = 3'd4;
   localparam upc_type UA_TENS_LO  = 3'd5;
   localparam upc_type UA_UNITS_HI = 3'd6;
   localparam upc_type UA_UNITS_LO = 3'd7;

   typedef struct packed {
      frame_type  frame;       // frame to load into the shifter, if any
      num_type    num;         // number prep: latch tens and units
      logic       digit_units; // segment frame uses the units digit
      logic       seg_low;     // second nibble of the digit's pair
      logic [1:0] seg_addr;    // low address bits of the segment write
      logic       done;        // end of program after this step
      upc_type    next;        // next step
   } ucode_type;

   // Control store: one word per step
   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      w = '{frame: FR_NONE, num: NUM_KEEP, digit_units: 1'b0, seg_low: 1'b0,
            seg_addr: 2'd0, done: 1'b1, next: UA_CMD};
      case (upc)
         UA_CMD: begin
            w.frame = FR_CMD;
         end
         UA_WRITE: begin
            w.frame = FR_WRITE;
         end
         UA_SHOW: begin
            w.num  = NUM_VALUE;
            w.done = 1'b0;
            w.next = UA_TENS_HI;
         end
         UA_INC: begin
            w.num  = NUM_INC;
            w.done = 1'b0;
            w.next = UA_TENS_HI;
         end
         UA_TENS_HI: begin
            w.frame    = FR_SEG;
            w.seg_addr = 2'd3;
            w.done     = 1'b0;
            w.next     = UA_TENS_LO;
         end
         UA_TENS_LO: begin
            w.frame    = FR_SEG;
            w.seg_low  = 1'b1;
            w.seg_addr = 2'd2;
            w.done     = 1'b0;
            w.next     = UA_UNITS_HI;
         end
         UA_UNITS_HI: begin
            w.frame       = FR_SEG;
            w.digit_units = 1'b1;
            w.seg_addr    = 2'd1;
            w.done        = 1'b0;
            w.next        = UA_UNITS_LO;
         end
         UA_UNITS_LO: begin
            w.frame       = FR_SEG;
            w.digit_units = 1'b1;
            w.seg_low     = 1'b1;
            w.seg_addr    = 2'd0;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

   // Segment nibble pair per decimal digit
   function automatic logic [3:0] seg_nibble(input logic [3:0] digit, input logic low);
      logic [7:0] pair;
      case (digit)
         4'd0:    pair = 8'hF5;
         4'd1:    pair = 8'h05;
         4'd2:    pair = 8'hD3;
         4'd3:    pair = 8'h97;
         4'd4:    pair = 8'h27;
         4'd5:    pair = 8'hB6;
         4'd6:    pair = 8'hF6;
         4'd7:    pair = 8'h15;
         4'd8:    pair = 8'hFF;
         4'd9:    pair = 8'hB7;
         default: pair = 8'h00;
      endcase
      return low ? pair[3:0] : pair[7:4];
   endfunction

endpackage

FILE: hw/rtl/lsw_req_if.sv
// Request channel: one beat per operation.
interface lsw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] command_code;
   logic [5:0] address;
   logic [3:0] nibble;
   logic [6:0] value;

   modport source (output valid, op, command_code, address, nibble, value, input ready);
   modport sink   (input valid, op, command_code, address, nibble, value, output ready);
endinterface

FILE: hw/rtl/lsw_rsp_if.sv
// Response channel: one beat per serial bit.
interface lsw_rsp_if;
   logic valid;
   logic ready;
   logic serial_bit;
   logic frame_end;
   logic last;

   modport source (output valid, serial_bit, frame_end, last, input ready);
   modport sink   (input valid, serial_bit, frame_end, last, output ready);
endinterface

FILE: hw/rtl/lcd_segment_serial_writer_top.sv
// Serial frame writer for a three-wire segment LCD controller. Each request beat is turned
// into serial bits, MSB first, one response beat per bit: op 0 sends a 12-bit command frame,
// op 1 a 13-bit nibble write, ops 2 and 3 four 13-bit segment writes (52 bits) showing a
// two-digit number (op 2 saturates the value to 99; op 3 steps an internal counter modulo
// 100 and shows it). A small microcode sequencer walks a control store: each step either
// prepares the digits or loads one frame into a shifter that emits a bit per cycle whenever
// the response register is empty or being taken. An item goes through dispatch, then for a
// number a step that splits it into digits, then per frame a load and its bits in turn.
// A request is taken only while the sequencer is idle; the response register lets the
// last bit of one item wait while the next item is taken.
module lcd_segment_serial_writer_top (
   input logic clock,
   input logic reset,
   lsw_req_if.sink   req_ch,
   lsw_rsp_if.source rsp_ch
);
   import lsw_pkg::*;

   // Sequencer state
   state_type          state_ff, state_in;
   upc_type            upc_ff, upc_in;
   logic [6:0]         count_ff, count_in;
   logic               final_ff, final_in;
   logic [3:0]         bits_left_ff, bits_left_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [7:0]         cmd_ff, cmd_in;
   logic [5:0]         addr_ff, addr_in;
   logic [3:0]         nib_ff, nib_in;
   logic [6:0]         value_ff, value_in;
   logic [3:0]         tens_ff, tens_in;
   logic [3:0]         units_ff, units_in;
   logic [FRAME_W-1:0] shift_ff, shift_in;
   logic               rsp_bit_ff, rsp_bit_in;
   logic               rsp_end_ff, rsp_end_in;
   logic               rsp_last_ff, rsp_last_in;

   ucode_type          ucw;
   logic               req_take;
   logic               push;
   logic [6:0]         num_sel;
   logic [6:0]         count_sat;
   logic [14:0]        prod;
   logic [3:0]         tens_calc;
   logic [6:0]         tens_x10;
   logic [6:0]         units_wide;
   logic [3:0]         seg_digit;
   logic [3:0]         seg_nib;

   assign ucw      = ucode_rom(upc_ff);
   assign req_take = req_ch.valid && req_ch.ready;
   assign push     = (state_ff == ST_SHIFT) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.serial_bit = rsp_bit_ff;
   assign rsp_ch.frame_end  = rsp_end_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // Number prep: saturate or step the counter, then split by multiply with 1/10
   always_comb begin
      count_sat = (count_ff > VALUE_MAX) ? VALUE_MAX : count_ff;
      if (ucw.num == NUM_INC) begin
         num_sel = (count_sat == VALUE_MAX) ? 7'd0 : count_sat + 7'd1;
      end else begin
         num_sel = (value_ff > VALUE_MAX) ? VALUE_MAX : value_ff;
      end
      prod       = {8'd0, num_sel} * {7'd0, DIV10_MUL};
      tens_calc  = prod[DIV10_SHIFT +: 4];
      tens_x10   = {tens_calc, 3'b000} + {2'b00, tens_calc, 1'b0};
      units_wide = num_sel - tens_x10;
   end

   // Segment nibble for the current step
   assign seg_digit = ucw.digit_units ? units_ff : tens_ff;
   assign seg_nib   = seg_nibble(seg_digit, ucw.seg_low);

   // Sequencer: dispatch, step execution and bit shifting
   always_comb begin
      state_in     = state_ff;
      upc_in       = upc_ff;
      count_in     = count_ff;
      final_in     = final_ff;
      bits_left_in = bits_left_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      nib_in       = nib_ff;
      value_in     = value_ff;
      tens_in      = tens_ff;
      units_in     = units_ff;
      shift_in     = shift_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               upc_in   = {1'b0, req_ch.op};
               cmd_in   = req_ch.command_code;
               addr_in  = req_ch.address;
               nib_in   = req_ch.nibble;
               value_in = req_ch.value;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (ucw.num != NUM_KEEP) begin
               tens_in  = tens_calc;
               units_in = units_wide[3:0];
               if (ucw.num == NUM_INC) begin
                  count_in = num_sel;
               end
            end
            final_in = ucw.done;
            case (ucw.frame)
               FR_CMD: begin
                  shift_in     = {MODE_CMD, cmd_ff, 2'b00};
                  bits_left_in = CMD_BITS;
                  state_in     = ST_SHIFT;
               end
               FR_WRITE: begin
                  shift_in     = {MODE_WRITE, addr_ff, nib_ff};
                  bits_left_in = WRITE_BITS;
                  state_in     = ST_SHIFT;
               end
               FR_SEG: begin
                  shift_in     = {MODE_WRITE, SEG_ADDR_HI, ucw.seg_addr, seg_nib};
                  bits_left_in = WRITE_BITS;
                  state_in     = ST_SHIFT;
               end
               default: begin
                  if (ucw.done) begin
                     state_in = ST_IDLE;
                  end else begin
                     upc_in = ucw.next;
                  end
               end
            endcase
         end
         ST_SHIFT: begin
            if (push) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = shift_ff[FRAME_W-1];
               rsp_end_in   = (bits_left_ff == 4'd1);
               rsp_last_in  = (bits_left_ff == 4'd1) && final_ff;
               shift_in     = {shift_ff[FRAME_W-2:0], 1'b0};
               bits_left_in = bits_left_ff - 4'd1;
               if (bits_left_ff == 4'd1) begin
                  if (final_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     upc_in   = ucw.next;
                     state_in = ST_RUN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= UA_CMD;
         count_ff     <= 7'd0;
         final_ff     <= 1'b0;
         bits_left_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         final_ff     <= final_in;
         bits_left_ff <= bits_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      nib_ff      <= nib_in;
      value_ff    <= value_in;
      tens_ff     <= tens_in;
      units_ff    <= units_in;
      shift_ff    <= shift_in;
      rsp_bit_ff  <= rsp_bit_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // Shifter never sits in the shift state with nothing left to send
   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (bits_left_ff != 4'd0))
      else $error("shift state with empty shifter");

   // Stored counter stays a two-digit number
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= VALUE_MAX))
      else $error("counter out of range");

   // The last bit of an item always closes a frame
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_end_ff)
      else $error("last bit not at frame end");

   // An accepted request starts the program
   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RUN))
      else $error("request not dispatched");

   // Digit split always yields decimal digits
   a_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && ucw.num != NUM_KEEP) |=>
         (tens_ff <= DIGIT_MAX && units_ff <= DIGIT_MAX))
      else $error("digit out of range");
`endif

endmodule

FILE: sim/lcd_segment_serial_writer_top_tb.sv
// Testbench for the LCD serial writer: random-stall handshakes, bit check against a predictor.
module lcd_segment_serial_writer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lsw_pkg::*;

   localparam int RANDOM_ITEMS   = 290;
   localparam int WRAP_AT        = 120;
   localparam int PAUSE_EVERY    = 70;
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int N_DIRECTED     = 20;

   // Segment nibble pair per digit: first goes to the odd address, second to the even one
   localparam logic [3:0] SEG_FIRST [10] = '{4'hF, 4'h0, 4'hD, 4'h9, 4'h2,
                                             4'hB, 4'hF, 4'h1, 4'hF, 4'hB};
   localparam logic [3:0] SEG_SECOND [10] = '{4'h5, 4'h5, 4'h3, 4'h7, 4'h7,
                                              4'h6, 4'h6, 4'h5, 4'hF, 4'h7};

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] command_code;
      logic [5:0] address;
      logic [3:0] nibble;
      logic [6:0] value;
   } req_item_type;

   typedef struct packed {
      logic serial_bit;
      logic frame_end;
      logic last;
   } serial_beat_type;

   // Directed row: frame_word is typed in only for single-frame extremes
   typedef struct packed {
      req_item_type item;
      bit           typed;
      logic [12:0]  frame_word;
   } directed_row_type;

   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      '{'{OP_CMD,   8'h00, 6'd0,  4'h0, 7'd0},   1'b1, 13'h0800},
      '{'{OP_CMD,   8'hFF, 6'd0,  4'h0, 7'd0},   1'b1, 13'h09FE},
      '{'{OP_CMD,   8'hA5, 6'd63, 4'hF, 7'd127}, 1'b0, 13'h0000},
      '{'{OP_WRITE, 8'h00, 6'd0,  4'h0, 7'd0},   1'b1, 13'h1400},
      '{'{OP_WRITE, 8'h00, 6'd63, 4'hF, 7'd0},   1'b1, 13'h17FF},
      '{'{OP_WRITE, 8'hFF, 6'h2A, 4'h5, 7'd127}, 1'b0, 13'h0000},
      '{'{OP_WRITE, 8'h00, 6'h15, 4'hA, 7'd0},   1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd0},   1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd9},   1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd10},  1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd99},  1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd100}, 1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd127}, 1'b0, 13'h0000},
      '{'{OP_SHOW,  8'hFF, 6'd63, 4'hF, 7'd55},  1'b0, 13'h0000},
      '{'{OP_INC,   8'h00, 6'd0,  4'h0, 7'd0},   1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd42},  1'b0, 13'h0000},
      '{'{OP_INC,   8'hFF, 6'd63, 4'hF, 7'd0},   1'b0, 13'h0000},
      '{'{OP_INC,   8'h00, 6'd0,  4'h0, 7'd127}, 1'b0, 13'h0000},
      '{'{OP_SHOW,  8'h00, 6'd0,  4'h0, 7'd88},  1'b0, 13'h0000},
      '{'{OP_CMD,   8'h5A, 6'd0,  4'h0, 7'd0},   1'b0, 13'h0000}
   };

   logic clock;
   logic reset;

   lsw_req_if req_ch ();
   lsw_rsp_if rsp_ch ();

   lcd_segment_serial_writer_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Expected serial bits, oldest first, and the shadow of the display counter
   serial_beat_type pending_bits[$];
   logic [6:0]      shown_tally = 7'd0;
   int              errors = 0;
   int              bits_checked = 0;
   int              counter_wraps = 0;
   int              op_seen [4] = '{0, 0, 0, 0};
   bit              src_rush = 1'b0;
   bit              snk_rush = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // One frame, MSB first; frame_end on its final bit
   function automatic void queue_frame(input logic [12:0] word, input int nbits);
      serial_beat_type b;
      for (int i = nbits - 1; i >= 0; i--) begin
         b.serial_bit = word[i];
         b.frame_end  = (i == 0);
         b.last       = 1'b0;
         pending_bits.push_back(b);
      end
   endfunction

   function automatic void queue_segment_write(input logic [5:0] addr, input logic [3:0] nib);
      queue_frame({MODE_WRITE, addr, nib}, 13);
   endfunction

   // Two digits, four write frames to addresses 7..4
   function automatic void queue_number(input logic [6:0] num);
      logic [6:0] n;
      int         tens;
      int         units;
      n     = (num > VALUE_MAX) ? VALUE_MAX : num;
      tens  = n / 10;
      units = n % 10;
      queue_segment_write(6'd7, SEG_FIRST[tens]);
      queue_segment_write(6'd6, SEG_SECOND[tens]);
      queue_segment_write(6'd5, SEG_FIRST[units]);
      queue_segment_write(6'd4, SEG_SECOND[units]);
   endfunction

   // Bits caused by one accepted request; the final one carries last
   function automatic void predict_item(input req_item_type it, input bit typed,
                                        input logic [12:0] frame_word);
      serial_beat_type tail;
      if (typed) begin
         queue_frame(frame_word, (it.op == OP_CMD) ? 12 : 13);
      end else begin
         case (it.op)
            OP_CMD: begin
               queue_frame({1'b0, MODE_CMD, it.command_code, 1'b0}, 12);
            end
            OP_WRITE: begin
               queue_segment_write(it.address, it.nibble);
            end
            OP_SHOW: begin
               queue_number(it.value);
            end
            OP_INC: begin
               // Counter saturates at 99 before it steps, so it wraps to 0
               shown_tally = (shown_tally >= VALUE_MAX) ? 7'd0 : shown_tally + 7'd1;
               if (shown_tally == 7'd0) counter_wraps++;
               queue_number(shown_tally);
            end
            default: begin
            end
         endcase
      end
      tail      = pending_bits.pop_back();
      tail.last = 1'b1;
      pending_bits.push_back(tail);
   endfunction

   function automatic req_item_type random_item(input logic [1:0] op);
      req_item_type it;
      it.op           = op;
      it.command_code = 8'($urandom_range(0, 255));
      it.address      = 6'($urandom_range(0, 63));
      it.nibble       = 4'($urandom_range(0, 15));
      it.value        = 7'($urandom_range(0, 127));
      return it;
   endfunction

   // Drive one request beat from a falling edge and wait for it to be taken
   task automatic send_item(input req_item_type it, input bit typed,
                            input logic [12:0] frame_word);
      int gap;
      if ($urandom_range(0, 15) == 0) src_rush = !src_rush;
      gap = src_rush ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= it.op;
      req_ch.command_code <= it.command_code;
      req_ch.address      <= it.address;
      req_ch.nibble       <= it.nibble;
      req_ch.value        <= it.value;
      do @(posedge clock); while (!req_ch.ready);
      op_seen[it.op]++;
      predict_item(it, typed, frame_word);
      @(negedge clock);
   endtask

   // Hold the request side until every expected bit has come out
   task automatic drain_pending();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_bits.size() != 0);
   endtask

   // Stimulus
   initial begin
      int random_sent;
      random_sent         = 0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_CMD;
      req_ch.command_code = 8'h00;
      req_ch.address      = 6'd0;
      req_ch.nibble       = 4'h0;
      req_ch.value        = 7'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].frame_word);
      end

      // Random mix, with one run of increments through the wrap
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent == WRAP_AT) begin
            do begin
               send_item(random_item(OP_INC), 1'b0, 13'h0000);
               random_sent++;
            end while (shown_tally != 7'd0);
         end
         if (random_sent % PAUSE_EVERY == PAUSE_EVERY / 2) drain_pending();
         send_item(random_item(2'($urandom_range(0, 3))), 1'b0, 13'h0000);
         random_sent++;
      end

      drain_pending();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d commands, %0d nibble writes, %0d shown values, %0d steps",
               op_seen[OP_CMD], op_seen[OP_WRITE], op_seen[OP_SHOW], op_seen[OP_INC]);
      $display("%0d serial bits checked, counter wrapped %0d times, %0d mismatches",
               bits_checked, counter_wraps, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Response side: random stalls per beat, with stall-free stretches
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) snk_rush = !snk_rush;
         stall = snk_rush ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      serial_beat_type exp_bit;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bits.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat serial_bit=%b frame_end=%b last=%b",
                     $time, rsp_ch.serial_bit, rsp_ch.frame_end, rsp_ch.last);
         end else begin
            exp_bit = pending_bits.pop_front();
            bits_checked++;
            if (rsp_ch.serial_bit !== exp_bit.serial_bit) begin
               errors++;
               $display("%0t: serial_bit expected %b actual %b",
                        $time, exp_bit.serial_bit, rsp_ch.serial_bit);
            end
            if (rsp_ch.frame_end !== exp_bit.frame_end) begin
               errors++;
               $display("%0t: frame_end expected %b actual %b",
                        $time, exp_bit.frame_end, rsp_ch.frame_end);
            end
            if (rsp_ch.last !== exp_bit.last) begin
               errors++;
               $display("%0t: last expected %b actual %b", $time, exp_bit.last, rsp_ch.last);
            end
         end
      end
   end

   // Watchdog: too long without a beat on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: watchdog expired, %0d bits still expected", $time, pending_bits.size());
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lsw_pkg.sv
hw/rtl/lsw_req_if.sv
hw/rtl/lsw_rsp_if.sv
hw/rtl/lcd_segment_serial_writer_top.sv
sim/lcd_segment_serial_writer_top_tb.sv
